/* rtl/core/nfra_pkg.sv */
// Shared types, constants and codes of the next-fit run allocator.
`default_nettype none
package nfra_pkg;

   // Heap geometry (a power of two keeps the range check a plain shift)
   localparam int HEAP_SLOTS = 256;
   localparam int SLOT_W     = $clog2(HEAP_SLOTS);
   localparam int IDX_W      = SLOT_W + 1;

   // Field widths fixed by the interface
   localparam int CNT_W      = 9;
   localparam int ADDR_W     = 64;
   localparam int STRIDE_W   = 13;
   localparam int STAT_W     = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 64;

   // Derived datapath widths
   localparam int CMP_W      = (IDX_W > CNT_W) ? IDX_W : CNT_W;
   localparam int SUM_W      = CMP_W + 1;
   localparam int DIV_W      = STRIDE_W + SLOT_W;
   localparam int DV_W       = DIV_W - 1;
   localparam int DCNT_W     = $clog2(SLOT_W + 1);

   // Operation codes
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // Result status codes
   localparam logic [STAT_W-1:0] RSP_OK       = 2'd0;
   localparam logic [STAT_W-1:0] RSP_NO_ROOM  = 2'd1;
   localparam logic [STAT_W-1:0] RSP_WAS_FREE = 2'd2;
   localparam logic [STAT_W-1:0] RSP_RANGE    = 2'd3;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_STRIDE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CPU_BASE       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GPU_BASE       = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SHADER_VISIBLE = 2'd3;

   typedef struct packed {
      logic              op;
      logic [CNT_W-1:0]  count;
      logic [ADDR_W-1:0] free_address;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] cpu_address;
      logic [ADDR_W-1:0] gpu_address;
      logic [STAT_W-1:0] status;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_MARK,
      ST_MUL,
      ST_ADD,
      ST_DIV,
      ST_CLEAR,
      ST_DONE
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic scan;
      logic mark;
      logic mul;
      logic add;
      logic div_init;
      logic div_step;
      logic clear;
      logic fail_room;
      logic fail_range;
      logic emit;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic alloc;
      logic count_zero;
      logic count_big;
      logic stride_zero;
      logic off_big;
      logic found;
      logic exhausted;
      logic div_last;
      logic sweep_last;
      logic slot_end;
   } sts_type;

endpackage
`default_nettype wire

/* rtl/core/nfra_ctrl.sv */
// Sequencer of the allocator: steps the datapath through allocate and free.
`default_nettype none
module nfra_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic              out_free,
   input  wire nfra_pkg::sts_type sts,
   output nfra_pkg::cmd_type      cmd,
   output logic                   idle
);
   import nfra_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      idle     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            idle = 1'b1;
            if (accept) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (sts.alloc) begin
               if (sts.count_zero) begin
                  state_in = ST_MUL;
               end else if (sts.count_big) begin
                  cmd.fail_room = 1'b1;
                  state_in      = ST_DONE;
               end else begin
                  state_in = ST_SCAN;
               end
            end else begin
               if (sts.count_zero) begin
                  state_in = ST_DONE;
               end else if (sts.stride_zero || sts.off_big) begin
                  cmd.fail_range = 1'b1;
                  state_in       = ST_DONE;
               end else begin
                  cmd.div_init = 1'b1;
                  state_in     = ST_DIV;
               end
            end
         end
         ST_SCAN: begin
            if (sts.found) begin
               state_in = ST_MARK;
            end else if (sts.exhausted) begin
               cmd.fail_room = 1'b1;
               state_in      = ST_DONE;
            end else begin
               cmd.scan = 1'b1;
            end
         end
         ST_MARK: begin
            cmd.mark = 1'b1;
            if (sts.sweep_last) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            cmd.add  = 1'b1;
            state_in = ST_DONE;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_CLEAR;
            end
         end
         ST_CLEAR: begin
            if (sts.slot_end) begin
               cmd.fail_range = 1'b1;
               state_in       = ST_DONE;
            end else begin
               cmd.clear = 1'b1;
               if (sts.sweep_last) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

/* rtl/core/nfra_dp.sv */
// Datapath of the allocator: slot map, cursor, scan, divider and address maths.
`default_nettype none
module nfra_dp (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_write,
   input  wire logic [nfra_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [nfra_pkg::CSR_DATA_W-1:0] csr_data,
   input  wire nfra_pkg::req_type              req_data,
   input  wire nfra_pkg::cmd_type              cmd,
   output nfra_pkg::sts_type                   sts,
   output nfra_pkg::rsp_type                   res
);
   import nfra_pkg::*;

   // Configuration
   logic [STRIDE_W-1:0] stride_ff;
   logic [ADDR_W-1:0]   cpu_base_ff;
   logic [ADDR_W-1:0]   gpu_base_ff;
   logic                shader_ff;

   // Persistent state
   logic [HEAP_SLOTS-1:0] used_ff;
   logic [SLOT_W-1:0]     cursor_ff;

   // Item and work registers
   logic              op_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [ADDR_W-1:0] offset_ff;
   logic [IDX_W-1:0]  scan_ff;
   logic [IDX_W-1:0]  start_ff;
   logic [CNT_W-1:0]  run_ff;
   logic              wrap_ff;
   logic              found_ff;
   logic              exh_ff;
   logic [CNT_W-1:0]  sw_ff;
   logic [DIV_W-1:0]  rem_ff;
   logic [DV_W-1:0]   dv_ff;
   logic [SLOT_W-1:0] quo_ff;
   logic [DCNT_W-1:0] dcnt_ff;
   logic [DIV_W-1:0]  prod_ff;
   rsp_type           res_ff;

   logic              slot_used;
   logic [CNT_W-1:0]  run_inc;
   logic [CNT_W-1:0]  sw_inc;
   logic [IDX_W-1:0]  scan_inc;
   logic              last_pos;
   logic              past_cursor;
   logic [SUM_W-1:0]  mark_sum;
   logic [SUM_W-1:0]  clear_sum;
   logic              div_ge;

   always_ff @(posedge clock) begin
      if (reset) begin
         stride_ff   <= STRIDE_W'(32);
         cpu_base_ff <= '0;
         gpu_base_ff <= '0;
         shader_ff   <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_SLOT_STRIDE:    stride_ff   <= csr_data[STRIDE_W-1:0];
            CSR_CPU_BASE:       cpu_base_ff <= csr_data;
            CSR_GPU_BASE:       gpu_base_ff <= csr_data;
            CSR_SHADER_VISIBLE: shader_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign slot_used   = used_ff[scan_ff[SLOT_W-1:0]];
   assign run_inc     = run_ff + 1'b1;
   assign sw_inc      = sw_ff + 1'b1;
   assign scan_inc    = scan_ff + 1'b1;
   assign last_pos    = (scan_ff == IDX_W'(HEAP_SLOTS - 1));
   assign past_cursor = (scan_inc >= IDX_W'(cursor_ff));
   assign mark_sum    = SUM_W'(start_ff) + SUM_W'(sw_ff);
   assign clear_sum   = SUM_W'(quo_ff) + SUM_W'(sw_ff);
   assign div_ge      = (DIV_W'(dv_ff) <= rem_ff);

   // Latched item
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= req_data.op;
         count_ff  <= req_data.count;
         offset_ff <= req_data.free_address - cpu_base_ff;
      end
   end

   // Next-fit scan: one slot per cycle, tracking the free run behind the candidate start
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
         exh_ff   <= 1'b0;
         wrap_ff  <= 1'b0;
      end else if (cmd.load) begin
         found_ff <= 1'b0;
         exh_ff   <= 1'b0;
         wrap_ff  <= 1'b0;
      end else if (cmd.scan) begin
         if (!slot_used && run_inc == count_ff) begin
            found_ff <= 1'b1;
         end else if (last_pos) begin
            if (wrap_ff) begin
               exh_ff <= 1'b1;
            end else begin
               wrap_ff <= 1'b1;
               exh_ff  <= (cursor_ff == '0);
            end
         end else if (slot_used) begin
            // second lap ends once the candidate reaches the cursor again
            exh_ff <= wrap_ff && past_cursor;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         scan_ff  <= IDX_W'(cursor_ff);
         start_ff <= IDX_W'(cursor_ff);
         run_ff   <= '0;
      end else if (cmd.scan && !(!slot_used && run_inc == count_ff)) begin
         if (last_pos) begin
            scan_ff  <= '0;
            start_ff <= '0;
            run_ff   <= '0;
         end else begin
            scan_ff <= scan_inc;
            if (slot_used) begin
               start_ff <= scan_inc;
               run_ff   <= '0;
            end else begin
               run_ff <= run_inc;
            end
         end
      end
   end

   // Slot map: one slot marked or cleared per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else if (cmd.mark) begin
         used_ff[mark_sum[SLOT_W-1:0]] <= 1'b1;
      end else if (cmd.clear) begin
         used_ff[clear_sum[SLOT_W-1:0]] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sw_ff <= '0;
      end else if (cmd.mark || cmd.clear) begin
         sw_ff <= sw_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= '0;
      end else if (cmd.mul) begin
         cursor_ff <= start_ff[SLOT_W-1:0];
      end
   end

   // Restoring divider, one quotient bit per cycle; the offset is known to be
   // below stride * HEAP_SLOTS here, so only SLOT_W bits remain.
   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         rem_ff  <= offset_ff[DIV_W-1:0];
         dv_ff   <= {stride_ff, {(SLOT_W-1){1'b0}}};
         quo_ff  <= '0;
         dcnt_ff <= '0;
      end else if (cmd.div_step) begin
         if (div_ge) begin
            rem_ff <= rem_ff - DIV_W'(dv_ff);
         end
         quo_ff  <= SLOT_W'({quo_ff, div_ge});
         dv_ff   <= dv_ff >> 1;
         dcnt_ff <= dcnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_ff <= DIV_W'(stride_ff) * DIV_W'(start_ff[SLOT_W-1:0]);
      end
   end

   // Result fields
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         res_ff <= '0;
      end else if (cmd.add) begin
         res_ff.cpu_address <= cpu_base_ff + ADDR_W'(prod_ff);
         res_ff.gpu_address <= shader_ff ? gpu_base_ff + ADDR_W'(prod_ff) : '0;
      end else if (cmd.fail_room) begin
         res_ff.status <= RSP_NO_ROOM;
      end else if (cmd.fail_range) begin
         res_ff.status <= RSP_RANGE;
      end else if (cmd.clear && !used_ff[clear_sum[SLOT_W-1:0]]) begin
         res_ff.status <= RSP_WAS_FREE;
      end
   end

   assign res = res_ff;

   always_comb begin
      sts.alloc       = (op_ff == OP_ALLOC);
      sts.count_zero  = (count_ff == '0);
      sts.count_big   = (CMP_W'(count_ff) > CMP_W'(HEAP_SLOTS));
      sts.stride_zero = (stride_ff == '0);
      sts.off_big     = (offset_ff >= ADDR_W'({stride_ff, {SLOT_W{1'b0}}}));
      sts.found       = found_ff;
      sts.exhausted   = exh_ff;
      sts.div_last    = (dcnt_ff == DCNT_W'(SLOT_W - 1));
      sts.sweep_last  = (sw_inc == count_ff);
      sts.slot_end    = (clear_sum >= SUM_W'(HEAP_SLOTS));
   end

endmodule
`default_nettype wire

/* rtl/core/next_fit_run_allocator.sv */
// Next-fit run allocator: 256-slot bitmap, one item at a time, registered result.
// Allocate: decode, scan, mark the run, multiply, add; the scan tests one slot per cycle
//   from the cursor and wraps.
// Free: a divider finds the first slot, then the run is cleared one slot per cycle.
// Throughput: one item in flight; the next is taken once the result is in the output reg.
// Reset (synchronous): map all free, cursor 0, registers to defaults; no clearing pass.
`default_nettype none
module next_fit_run_allocator (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire nfra_pkg::req_type              req_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output nfra_pkg::rsp_type                   rsp_data,
   input  wire logic                           csr_write,
   input  wire logic [nfra_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [nfra_pkg::CSR_DATA_W-1:0] csr_data
);
   import nfra_pkg::*;

   cmd_type cmd;
   sts_type sts;
   rsp_type res;
   logic    idle;
   logic    accept;
   logic    out_free;

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   // An item is taken only while the sequencer is idle
   assign req_stall = !idle;
   assign accept    = req_valid && !req_stall;

   // The output register may be reloaded in the cycle its item leaves
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   nfra_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .out_free (out_free),
      .sts      (sts),
      .cmd      (cmd),
      .idle     (idle)
   );

   nfra_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .res       (res)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

/* tb/nfra_checker.sv */
// Checker for the next-fit run allocator: tracks the bitmap, predicts results, compares.
module nfra_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   input  wire logic                            req_stall,
   input  wire nfra_pkg::req_type               req_data,
   input  wire logic                            rsp_valid,
   input  wire logic                            rsp_stall,
   input  wire nfra_pkg::rsp_type               rsp_data,
   input  wire logic                            csr_write,
   input  wire logic [nfra_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [nfra_pkg::CSR_DATA_W-1:0] csr_data,
   output int                                   mismatches,
   output int                                   outstanding
);
   import nfra_pkg::*;

   // Shadow of the block's state and registers
   bit                  slot_used [HEAP_SLOTS];
   logic [SLOT_W-1:0]   cursor;
   logic [STRIDE_W-1:0] stride;
   logic [ADDR_W-1:0]   cpu_base_r;
   logic [ADDR_W-1:0]   gpu_base_r;
   logic                visible;

   rsp_type due_results [$];

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] want,
                                  input logic [ADDR_W-1:0] got);
      $display("mismatch in %s: expected %h, got %h at %0t", what, want, got, $time);
      mismatches++;
   endtask

   function automatic rsp_type allocate_run(input logic [CNT_W-1:0] n);
      rsp_type res;
      int      pos;
      bit      fits;
      res        = '0;
      res.status = RSP_NO_ROOM;
      pos        = cursor;
      for (int tries = 0; tries < HEAP_SLOTS; tries++) begin
         fits = (pos + n <= HEAP_SLOTS);
         for (int i = 0; fits && i < n; i++)
            if (slot_used[pos + i]) fits = 1'b0;
         if (fits) begin
            for (int i = 0; i < n; i++) slot_used[pos + i] = 1'b1;
            cursor          = pos[SLOT_W-1:0];
            res.cpu_address = cpu_base_r + ADDR_W'(stride) * ADDR_W'(pos);
            res.gpu_address = visible ? gpu_base_r + ADDR_W'(stride) * ADDR_W'(pos) : '0;
            res.status      = RSP_OK;
            return res;
         end
         pos = (pos + 1) % HEAP_SLOTS;
      end
      return res;
   endfunction

   function automatic rsp_type free_run(input logic [CNT_W-1:0] n,
                                        input logic [ADDR_W-1:0] addr);
      rsp_type           res;
      logic [ADDR_W-1:0] first;
      logic [ADDR_W-1:0] slot;
      bit                off_end;
      bit                was_free;
      res      = '0;
      off_end  = 1'b0;
      was_free = 1'b0;
      if (n == 0) begin
         res.status = RSP_OK;
         return res;
      end
      if (stride == 0) begin
         res.status = RSP_RANGE;
         return res;
      end
      // address below the base wraps to a huge index
      first = (addr - cpu_base_r) / ADDR_W'(stride);
      for (int i = 0; i < n; i++) begin
         if (first >= HEAP_SLOTS) begin
            off_end = 1'b1;
            break;
         end
         slot = first + ADDR_W'(i);
         if (slot >= HEAP_SLOTS) begin
            off_end = 1'b1;
            continue;
         end
         if (!slot_used[slot[SLOT_W-1:0]]) was_free = 1'b1;
         slot_used[slot[SLOT_W-1:0]] = 1'b0;
      end
      res.status = off_end ? RSP_RANGE : (was_free ? RSP_WAS_FREE : RSP_OK);
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         foreach (slot_used[i]) slot_used[i] = 1'b0;
         cursor     = '0;
         stride     = STRIDE_W'(32);
         cpu_base_r = '0;
         gpu_base_r = '0;
         visible    = 1'b0;
         due_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_results.size() == 0) begin
               report_mismatch("unexpected item, status", '0, ADDR_W'(rsp_data.status));
            end else begin
               want = due_results.pop_front();
               if (rsp_data.cpu_address !== want.cpu_address)
                  report_mismatch("cpu_address", want.cpu_address, rsp_data.cpu_address);
               if (rsp_data.gpu_address !== want.gpu_address)
                  report_mismatch("gpu_address", want.gpu_address, rsp_data.gpu_address);
               if (rsp_data.status !== want.status)
                  report_mismatch("status", ADDR_W'(want.status), ADDR_W'(rsp_data.status));
            end
         end
         if (csr_write) begin
            case (csr_index)
               CSR_SLOT_STRIDE:    stride     = csr_data[STRIDE_W-1:0];
               CSR_CPU_BASE:       cpu_base_r = csr_data;
               CSR_GPU_BASE:       gpu_base_r = csr_data;
               CSR_SHADER_VISIBLE: visible    = csr_data[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            if (req_data.op == OP_ALLOC)
               due_results.push_back(allocate_run(req_data.count));
            else
               due_results.push_back(free_run(req_data.count, req_data.free_address));
         end
      end
      outstanding <= due_results.size();
   end

endmodule

/* tb/tb.sv */
// Testbench top for the next-fit run allocator: stimulus, idling and the verdict.
module tb;
   import nfra_pkg::*;

   // Every input of the block starts from a known value; reset is held from time zero
   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   req_type               req_data  = '0;
   logic                  rsp_stall = 1'b0;
   logic                  csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_SLOT_STRIDE;
   logic [CSR_DATA_W-1:0] csr_data  = '0;

   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_data;

   int mismatches;
   int outstanding;

   // Idling odds in percent, changed per phase
   int tx_idle_pct = 14;
   int rx_idle_pct = 69;

   // Local copy of the registers that shape free addresses
   logic [STRIDE_W-1:0] cfg_stride   = STRIDE_W'(32);
   logic [ADDR_W-1:0]   cfg_cpu_base = '0;

   next_fit_run_allocator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   nfra_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always #1 clock = ~clock;

   // Receiver back-pressure: fresh coin every cycle
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rx_idle_pct);
   end

   // Hard stop; the slowest legal run is far shorter than this
   initial begin
      #3_000_000;
      $display("FAILURE");
      $finish;
   end

   // Somewhere inside the given slot, so the truncating divide lands on it
   function automatic logic [ADDR_W-1:0] address_of_slot(input int slot);
      logic [ADDR_W-1:0] offset;
      offset = (cfg_stride > 1) ? ADDR_W'($urandom_range(cfg_stride - 1)) : '0;
      return cfg_cpu_base + ADDR_W'(cfg_stride) * ADDR_W'(slot) + offset;
   endfunction

   // Holds the write strobe high; the caller lowers it after the last write
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
   endtask

   // Only called with the block idle: after reset or after a drain
   task automatic set_registers(input logic [CSR_DATA_W-1:0] stride_word,
                                input logic [CSR_DATA_W-1:0] cpu,
                                input logic [CSR_DATA_W-1:0] gpu,
                                input logic [CSR_DATA_W-1:0] vis_word);
      write_reg(CSR_SLOT_STRIDE, stride_word);
      write_reg(CSR_CPU_BASE, cpu);
      write_reg(CSR_GPU_BASE, gpu);
      write_reg(CSR_SHADER_VISIBLE, vis_word);
      csr_write    <= 1'b0;
      cfg_stride   = stride_word[STRIDE_W-1:0];
      cfg_cpu_base = cpu;
   endtask

   // Optional idle gap, then present the item and hold it until taken
   task automatic send_item(input logic op, input logic [CNT_W-1:0] n,
                            input logic [ADDR_W-1:0] addr);
      req_type item;
      item.op           = op;
      item.count        = n;
      item.free_address = addr;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Stop sending and wait until every expected item has come back.
   // The checker's count is registered, hence the first wait.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Mostly short, well-formed allocate/free traffic, plus some noise
   task automatic random_items(input int total);
      int pick;
      for (int k = 0; k < total; k++) begin
         pick = $urandom_range(99);
         if (pick < 42)
            send_item(OP_ALLOC, CNT_W'($urandom_range(1, 8)), {$urandom, $urandom});
         else if (pick < 47)
            send_item(OP_ALLOC, CNT_W'($urandom_range(9, 300)), {$urandom, $urandom});
         else if (pick < 90)
            send_item(OP_FREE, CNT_W'($urandom_range(1, 8)),
                      address_of_slot($urandom_range(HEAP_SLOTS - 1)));
         else
            send_item(1'($urandom_range(1)), CNT_W'($urandom_range(511)), {$urandom, $urandom});
         // once, mid-phase: let the block empty out completely before carrying on
         if (k == total / 2 && tx_idle_pct == 14) drain();
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed part, first idling mix ----
      tx_idle_pct = 14;
      rx_idle_pct = 69;
      // bases near the top of the address space so results wrap
      set_registers(64'd32, 64'hFFFF_FFFF_FFFF_FF00, 64'hFFFF_FFFF_FFFF_FFFF, 64'd1);
      send_item(OP_ALLOC, 0, '0);                  // zero count: ok at the cursor, nothing marked
      send_item(OP_ALLOC, 1, '1);                  // slot 0, address field ignored
      send_item(OP_ALLOC, 4, '0);                  // slots 1..4
      send_item(OP_ALLOC, 256, '0);                // bigger than what is left
      send_item(OP_ALLOC, 511, '0);                // bigger than the heap
      send_item(OP_FREE, 0, '1);                   // zero count free: no change
      send_item(OP_FREE, 1, address_of_slot(0));   // plain free
      send_item(OP_FREE, 1, address_of_slot(0));   // same slot again: already free
      send_item(OP_FREE, 2, cfg_cpu_base - 1);     // below the base: huge index
      send_item(OP_FREE, 4, '1);                   // top of the address space
      send_item(OP_FREE, 10, address_of_slot(250)); // runs off the end of the heap
      send_item(OP_FREE, 511, address_of_slot(0)); // clears the lot, tail out of range
      send_item(OP_ALLOC, 256, '0);                // whole heap, search wraps to slot 0
      send_item(OP_ALLOC, 1, '0);                  // heap full
      send_item(OP_FREE, 256, address_of_slot(0)); // exact full-heap free
      send_item(OP_ALLOC, 255, '0);
      send_item(OP_ALLOC, 1, '0);                  // only the last slot is left
      send_item(OP_ALLOC, 1, '0);                  // full again
      drain();

      // zero stride: frees are all out of range, addresses collapse onto the base
      set_registers(64'd0, {$urandom, $urandom}, {$urandom, $urandom}, 64'hFFFF_FFFF_FFFF_FFFE);
      send_item(OP_FREE, 3, {$urandom, $urandom});
      send_item(OP_ALLOC, 0, '0);
      send_item(OP_FREE, 1, '0);
      drain();

      // widest stride field, junk above it in the write data
      set_registers({51'h7_1234_5678_9ABC, 13'h1FFF}, {$urandom, $urandom},
                    {$urandom, $urandom}, 64'd1);
      send_item(OP_FREE, 256, address_of_slot(0));
      send_item(OP_ALLOC, 2, '0);
      send_item(OP_FREE, 2, address_of_slot(0));
      drain();

      // ---- random part, three idling mixes ----
      set_registers(64'd32, {$urandom, $urandom}, {$urandom, $urandom}, 64'd1);
      random_items(130);
      drain();

      tx_idle_pct = 69;
      rx_idle_pct = 14;
      set_registers(64'd1, 64'd0, {$urandom, $urandom}, 64'd0);
      random_items(130);
      drain();

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      set_registers(64'd4096, {$urandom, $urandom}, '1, 64'd1);
      random_items(140);
      drain();

      // room for any stray item to surface after the last expected one
      repeat (800) @(posedge clock);
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

/* next_fit_run_allocator.f */
rtl/core/nfra_pkg.sv
rtl/core/nfra_ctrl.sv
rtl/core/nfra_dp.sv
rtl/core/next_fit_run_allocator.sv
tb/nfra_checker.sv
tb/tb.sv
